// ===== rtl/etc_pkg.sv =====
// Package for the elapsed time counter with alarm.
// Holds the request and mode codes, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package etc_pkg;

  // Request codes carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_PAUSE  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // Internal mode, one-hot.
  typedef enum logic [2:0] {
    MODE_PAUSED   = 3'b001,
    MODE_RUN      = 3'b010,
    MODE_FINISHED = 3'b100
  } mode_e;

  // Mode codes as shown in the run_mode field.
  localparam logic [1:0] RunModePaused   = 2'd0;
  localparam logic [1:0] RunModeRun      = 2'd1;
  localparam logic [1:0] RunModeFinished = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgMaxHours    = 2'd0;
  localparam logic [1:0] CfgAlarmHour   = 2'd1;
  localparam logic [1:0] CfgAlarmMinute = 2'd2;

  // Register reset values.
  localparam logic [7:0] MaxHoursReset    = 8'd99;
  localparam logic [7:0] AlarmHourReset   = 8'd99;
  localparam logic [5:0] AlarmMinuteReset = 6'd59;

  localparam logic [6:0] SecsPerMin   = 7'd60;
  localparam logic [6:0] MinsPerHour  = 7'd60;

  typedef struct packed {
    logic [7:0] max_hours;
    logic [7:0] alarm_hour;
    logic [5:0] alarm_minute;
  } cfg_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] last_second;
    logic       last_valid;
  } state_t;

  typedef struct packed {
    logic [1:0] run_mode;
    logic       relay_on;
    logic       beep_pulse;
    logic [7:0] count_hours;
    logic [5:0] count_minutes;
    logic [5:0] count_seconds;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/etc_if.sv =====
// Channel interfaces of the elapsed time counter: request, result and
// configuration write. Each carries valid, ready and its payload.
// Depends on nothing.
`default_nettype none

interface etc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] rtc_second_bcd;

  modport source (output valid, output req_type, output rtc_second_bcd, input ready);
  modport sink   (input valid, input req_type, input rtc_second_bcd, output ready);
endinterface

interface etc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] run_mode;
  logic       relay_on;
  logic       beep_pulse;
  logic [7:0] count_hours;
  logic [5:0] count_minutes;
  logic [5:0] count_seconds;

  modport source (output valid, output run_mode, output relay_on, output beep_pulse,
                  output count_hours, output count_minutes, output count_seconds,
                  input ready);
  modport sink   (input valid, input run_mode, input relay_on, input beep_pulse,
                  input count_hours, input count_minutes, input count_seconds,
                  output ready);
endinterface

interface etc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/etc_step.sv =====
// Next-state and result logic of the elapsed time counter for one request.
// Purely combinational; depends on etc_pkg.
`default_nettype none

module etc_step
  import etc_pkg::*;
(
  input  state_t     state_i,
  input  cfg_t       cfg_i,
  input  logic [1:0] req_type_i,
  input  logic [6:0] rtc_second_bcd_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [6:0] cur_sec;
  logic       sample_ok;
  logic [5:0] cur6;
  logic [6:0] delta;
  logic [6:0] sec_sum;
  logic       carry_s;
  logic [6:0] sec_wrap;
  logic [6:0] min_inc;
  logic       carry_m;
  logic [8:0] hours_inc;
  logic       over;
  logic [7:0] new_h;
  logic [5:0] new_m;
  logic [5:0] new_s;
  logic       fire;
  logic       advance;
  logic       beep;
  logic [1:0] mode_code;
  state_t     nxt;

  // Decode the BCD second: tens * 10 + units.
  assign cur_sec   = (7'(rtc_second_bcd_i[6:4]) << 3) + (7'(rtc_second_bcd_i[6:4]) << 1)
                   + 7'(rtc_second_bcd_i[3:0]);
  assign sample_ok = cur_sec < SecsPerMin;
  assign cur6      = cur_sec[5:0];

  // Forward distance since the last sample, modulo 60.
  always_comb begin
    if (state_i.last_second < cur6) begin
      delta = cur_sec - {1'b0, state_i.last_second};
    end else begin
      delta = cur_sec + SecsPerMin - {1'b0, state_i.last_second};
    end
  end

  // Carry chain seconds -> minutes -> hours, with the hour wrap.
  assign sec_sum   = {1'b0, state_i.seconds} + delta;
  assign carry_s   = sec_sum >= SecsPerMin;
  assign sec_wrap  = carry_s ? (sec_sum - SecsPerMin) : sec_sum;
  assign min_inc   = {1'b0, state_i.minutes} + {6'd0, carry_s};
  assign carry_m   = min_inc >= MinsPerHour;
  assign hours_inc = {1'b0, state_i.hours} + 9'd1;
  assign over      = carry_m && (hours_inc > {1'b0, cfg_i.max_hours});

  assign new_h = over ? 8'd0 : (carry_m ? hours_inc[7:0] : state_i.hours);
  assign new_m = carry_m ? 6'd0 : min_inc[5:0];
  assign new_s = over ? 6'd0 : sec_wrap[5:0];
  assign fire  = (new_h == cfg_i.alarm_hour) && (new_m >= cfg_i.alarm_minute);

  assign advance = state_i.last_valid && (state_i.mode == MODE_RUN)
                 && (cur6 != state_i.last_second);

  // Apply the request to the state.
  always_comb begin
    nxt  = state_i;
    beep = 1'b0;
    case (req_type_i)
      REQ_SAMPLE: begin
        if (sample_ok) begin
          if (advance) begin
            nxt.hours   = new_h;
            nxt.minutes = new_m;
            nxt.seconds = new_s;
            if (fire) begin
              nxt.mode = MODE_FINISHED;
              beep     = 1'b1;
            end
          end
          nxt.last_second = cur6;
          nxt.last_valid  = 1'b1;
        end
      end
      REQ_PAUSE: begin
        case (state_i.mode)
          MODE_RUN:    nxt.mode = MODE_PAUSED;
          MODE_PAUSED: nxt.mode = MODE_RUN;
          default: begin
            nxt.hours   = 8'd0;
            nxt.minutes = 6'd0;
            nxt.seconds = 6'd0;
            nxt.mode    = MODE_RUN;
          end
        endcase
      end
      REQ_CLEAR: begin
        if (state_i.mode != MODE_FINISHED) begin
          nxt.hours   = 8'd0;
          nxt.minutes = 6'd0;
          nxt.seconds = 6'd0;
        end
      end
      default: ;
    endcase
  end

  // Result fields follow the updated state.
  always_comb begin
    case (nxt.mode)
      MODE_RUN:      mode_code = RunModeRun;
      MODE_FINISHED: mode_code = RunModeFinished;
      default:       mode_code = RunModePaused;
    endcase
  end

  assign result_o.run_mode      = mode_code;
  assign result_o.beep_pulse    = beep;
  assign result_o.relay_on      = nxt.mode == MODE_RUN;
  assign result_o.count_hours   = nxt.hours;
  assign result_o.count_minutes = nxt.minutes;
  assign result_o.count_seconds = nxt.seconds;
  assign state_o                = nxt;

endmodule

`default_nettype wire

// ===== rtl/elapsed_time_counter_with_alarm_unit.sv =====
// Elapsed time counter (stopwatch) with alarm: top level.
// Usage:
//   in_i  carries one request word: a BCD clock-second sample, a pause key
//         or a clear key. Every accepted word yields exactly one result word.
//   out_o carries the mode, relay, beep pulse and hours:minutes:seconds count
//         after that request.
//   cfg_i writes max_hours (index 0), alarm_hour (1) and alarm_minute (2);
//         it is always ready and should be used only while the block is idle.
// A word's result is registered at the edge that accepts it, in the result
// register or, while the receiver stalls, the skid register. Throughput is
// one word per cycle while in_i.ready is high, set by the carry/compare logic.
// A two-entry output buffer (result register plus skid register) lets the
// block keep accepting while the receiver stalls; in_i.ready drops only when
// both entries hold results.
// Reset clears the count, the last sample and the output buffer, sets the
// mode to paused and loads the register defaults 99, 99 and 59.
// Depends on etc_pkg, the interfaces in etc_if and etc_step.
`default_nettype none

module elapsed_time_counter_with_alarm_unit
  import etc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  etc_in_if.sink    in_i,
  etc_out_if.source out_o,
  etc_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t step_res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    in_accept;
  logic    out_fire;

  assign in_i.ready  = !skid_valid_q;
  assign cfg_i.ready = 1'b1;
  assign in_accept   = in_i.valid && in_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_hours    <= MaxHoursReset;
      cfg_q.alarm_hour   <= AlarmHourReset;
      cfg_q.alarm_minute <= AlarmMinuteReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMaxHours:    cfg_q.max_hours    <= cfg_i.data;
        CfgAlarmHour:   cfg_q.alarm_hour   <= cfg_i.data;
        CfgAlarmMinute: cfg_q.alarm_minute <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  etc_step u_step (
    .state_i          (state_q),
    .cfg_i            (cfg_q),
    .req_type_i       (in_i.req_type),
    .rtc_second_bcd_i (in_i.rtc_second_bcd),
    .state_o          (state_d),
    .result_o         (step_res)
  );

  // Counter state advances on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= MODE_PAUSED;
      state_q.hours       <= 8'd0;
      state_q.minutes     <= 6'd0;
      state_q.seconds     <= 6'd0;
      state_q.last_second <= 6'd0;
      state_q.last_valid  <= 1'b0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Output buffer control: result register in front, skid register behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= step_res;
      end
    end else if (in_accept) begin
      if (out_valid_q) begin
        skid_q <= step_res;
      end else begin
        out_q <= step_res;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.run_mode      = out_q.run_mode;
  assign out_o.relay_on      = out_q.relay_on;
  assign out_o.beep_pulse    = out_q.beep_pulse;
  assign out_o.count_hours   = out_q.count_hours;
  assign out_o.count_minutes = out_q.count_minutes;
  assign out_o.count_seconds = out_q.count_seconds;

`ifndef SYNTHESIS
  // The skid register is only filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without a result in front");

  // A beep is only ever reported together with the finished mode.
  a_beep_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.beep_pulse) |-> (out_q.run_mode == RunModeFinished))
    else $error("beep without finished mode");

  // The relay follows the running mode.
  a_relay_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.relay_on == (out_q.run_mode == RunModeRun)))
    else $error("relay does not match run mode");

  // Seconds and minutes of the count never leave 0 to 59.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.seconds < 6'd60) && (state_q.minutes < 6'd60))
    else $error("count out of range");

  // A word that finds the buffer with a free entry is held there next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !out_fire) |=> out_valid_q)
    else $error("accepted word lost");
`endif

endmodule

`default_nettype wire
